>>> rtl/core/fprc_pkg.sv
`default_nettype none

package fprc_pkg;

    // field widths
    localparam int unsigned TIME_W    = 63;
    localparam int unsigned OFS_W     = 41;
    localparam int unsigned PERIOD_W  = 32;
    localparam int unsigned PHASE_W   = 21;
    localparam int unsigned RATE_W    = 16;
    localparam int unsigned ERR_W     = 34;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 63;

    // shared divider: 64-bit dividend, divisor up to 4 * period
    localparam int unsigned DVD_W     = 64;
    localparam int unsigned DIV_W     = PERIOD_W + 2;
    localparam int unsigned REM_W     = DIV_W + 1;
    localparam int unsigned DIV_STEPS = DVD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // nominal * |error| and the signed quotient
    localparam int unsigned PROD_W    = RATE_W + ERR_W;
    localparam int unsigned Q_W       = PROD_W + 1;
    localparam int unsigned SUM_W     = Q_W + 1;

    // reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(33333);
    localparam logic [RATE_W-1:0]   NOMINAL_RST = RATE_W'(7680);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PHASE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = CFG_IDX_W'(3);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PULSE,
        ST_ELAPSED,
        ST_DIV_REM,
        ST_DIFF,
        ST_WRAP,
        ST_MUL,
        ST_DIV_RATE,
        ST_QUOT,
        ST_RATE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/frame_phase_rate_corrector_unit.sv
// Frame phase rate corrector.
// Input channel (s_valid/s_ready): one frame timestamp in the camera time base plus
// the signed camera-to-pulse clock offset. Result channel (m_valid/m_ready): the
// wrapped phase error against the pulse train, the corrected frame rate (saturated
// to 0..65535, 1/256 Hz units) and a flag telling whether that rate differs from
// the previously stored one. Configuration goes through cfg_we/cfg_addr/cfg_wdata:
// 0 pulse period, 1 train start time, 2 phase offset, 3 nominal rate; other
// indexes are ignored. Write only while the block is idle.
// All work runs through one shift-subtract divider, once for elapsed % period
// (64 steps) and once for nominal * error / (4 * period) (64 steps), plus the
// steps pulse, elapsed, diff, wrap, mul, quot and rate.
// One item at a time: s_ready is high only in idle, so a new item is taken only
// after the last one has been loaded into the output register.
// The result sits in an output register; a new item may be taken while it waits.
// If the receiver stalls, the next finished item holds in its last step until the
// output register frees up.
// Reset: config registers and the stored current rate return to their defaults
// (period 33333, start 0, offset 0, nominal 7680, current rate 7680); no result
// is pending.
`default_nettype none

module frame_phase_rate_corrector_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_we,
    input  wire logic [fprc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [fprc_pkg::CFG_W-1:0]           cfg_wdata,

    input  wire logic                                 s_valid,
    output      logic                                 s_ready,
    input  wire logic [fprc_pkg::TIME_W-1:0]          s_frame_time_us,
    input  wire logic signed [fprc_pkg::OFS_W-1:0]    s_clock_offset_us,

    output      logic                                 m_valid,
    input  wire logic                                 m_ready,
    output      logic signed [fprc_pkg::ERR_W-1:0]    m_phase_error_us,
    output      logic [fprc_pkg::RATE_W-1:0]          m_new_rate,
    output      logic                                 m_rate_changed
);

    localparam int unsigned DVD_W = fprc_pkg::DVD_W;
    localparam int unsigned DIV_W = fprc_pkg::DIV_W;
    localparam int unsigned REM_W = fprc_pkg::REM_W;
    localparam int unsigned ERR_W = fprc_pkg::ERR_W;
    localparam int unsigned Q_W   = fprc_pkg::Q_W;
    localparam int unsigned SUM_W = fprc_pkg::SUM_W;
    localparam int unsigned CNT_W = fprc_pkg::CNT_W;

    // configuration
    logic [fprc_pkg::PERIOD_W-1:0]       period_reg;
    logic [fprc_pkg::TIME_W-1:0]         start_reg;
    logic signed [fprc_pkg::PHASE_W-1:0] phase_reg;
    logic [fprc_pkg::RATE_W-1:0]         nominal_reg;
    logic [fprc_pkg::RATE_W-1:0]         current_rate_reg, current_rate_next;

    // sequencer and datapath
    fprc_pkg::state_t              state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [fprc_pkg::TIME_W-1:0]   frame_reg, frame_next;
    logic signed [fprc_pkg::OFS_W-1:0] ofs_reg, ofs_next;
    logic [DVD_W-1:0]              dvd_reg, dvd_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [DIV_W-1:0]              divisor_reg, divisor_next;
    logic signed [ERR_W-1:0]       diff_reg, diff_next;
    logic                          neg_reg, neg_next;
    logic signed [Q_W-1:0]         q_reg, q_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic signed [ERR_W-1:0]       m_err_reg, m_err_next;
    logic [fprc_pkg::RATE_W-1:0]   m_rate_reg, m_rate_next;
    logic                          m_chg_reg, m_chg_next;

    // shared divider step
    logic [REM_W-1:0]              rem_sh;
    logic [REM_W-1:0]              rem_sub;
    logic                          div_ge;

    logic [fprc_pkg::PERIOD_W-1:0] period_eff;
    logic [ERR_W-1:0]              diff_mag;
    logic [fprc_pkg::PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]       rate_sum;
    logic [fprc_pkg::RATE_W-1:0]   rate_sat;
    logic                          out_load;

    // a zero period behaves as one
    assign period_eff = (period_reg == '0) ? fprc_pkg::PERIOD_W'(1) : period_reg;

    assign rem_sh  = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, divisor_reg});
    assign rem_sub = rem_sh - {1'b0, divisor_reg};

    assign diff_mag = diff_reg[ERR_W-1] ? ERR_W'(-diff_reg) : ERR_W'(diff_reg);
    assign prod     = fprc_pkg::PROD_W'(nominal_reg) * fprc_pkg::PROD_W'(diff_mag);

    assign rate_sum = $signed({{(SUM_W-fprc_pkg::RATE_W){1'b0}}, nominal_reg})
                    + SUM_W'(q_reg);

    always_comb begin
        if (rate_sum < 0) begin
            rate_sat = '0;
        end else if (rate_sum > $signed({{(SUM_W-fprc_pkg::RATE_W){1'b0}},
                                        {fprc_pkg::RATE_W{1'b1}}})) begin
            rate_sat = '1;
        end else begin
            rate_sat = rate_sum[fprc_pkg::RATE_W-1:0];
        end
    end

    // config port: plain write, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= fprc_pkg::PERIOD_RST;
            start_reg   <= '0;
            phase_reg   <= '0;
            nominal_reg <= fprc_pkg::NOMINAL_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                fprc_pkg::REG_PERIOD:  period_reg  <= cfg_wdata[fprc_pkg::PERIOD_W-1:0];
                fprc_pkg::REG_START:   start_reg   <= cfg_wdata[fprc_pkg::TIME_W-1:0];
                fprc_pkg::REG_PHASE:   phase_reg   <= $signed(cfg_wdata[fprc_pkg::PHASE_W-1:0]);
                fprc_pkg::REG_NOMINAL: nominal_reg <= cfg_wdata[fprc_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= fprc_pkg::ST_IDLE;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
            current_rate_reg <= fprc_pkg::NOMINAL_RST;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            m_valid_reg      <= m_valid_next;
            current_rate_reg <= current_rate_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg   <= frame_next;
        ofs_reg     <= ofs_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        diff_reg    <= diff_next;
        neg_reg     <= neg_next;
        q_reg       <= q_next;
        m_err_reg   <= m_err_next;
        m_rate_reg  <= m_rate_next;
        m_chg_reg   <= m_chg_next;
    end

    always_comb begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        frame_next        = frame_reg;
        ofs_next          = ofs_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        divisor_next      = divisor_reg;
        diff_next         = diff_reg;
        neg_next          = neg_reg;
        q_next            = q_reg;
        m_err_next        = m_err_reg;
        m_rate_next       = m_rate_reg;
        m_chg_next        = m_chg_reg;
        current_rate_next = current_rate_reg;
        out_load          = 1'b0;
        s_ready           = 1'b0;

        unique case (state_reg)
            fprc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    frame_next = s_frame_time_us;
                    ofs_next   = s_clock_offset_us;
                    state_next = fprc_pkg::ST_PULSE;
                end
            end
            fprc_pkg::ST_PULSE: begin
                // pulse time, modulo 2^64
                dvd_next   = {1'b0, frame_reg} + DVD_W'(ofs_reg);
                state_next = fprc_pkg::ST_ELAPSED;
            end
            fprc_pkg::ST_ELAPSED: begin
                dvd_next     = dvd_reg - {1'b0, start_reg};
                rem_next     = '0;
                divisor_next = {2'b00, period_eff};
                cnt_next     = '0;
                state_next   = fprc_pkg::ST_DIV_REM;
            end
            fprc_pkg::ST_DIV_REM, fprc_pkg::ST_DIV_RATE: begin
                rem_next = div_ge ? rem_sub : rem_sh;
                dvd_next = {dvd_reg[DVD_W-2:0], div_ge};
                if (cnt_reg == CNT_W'(fprc_pkg::DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = (state_reg == fprc_pkg::ST_DIV_REM) ?
                                 fprc_pkg::ST_DIFF : fprc_pkg::ST_QUOT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            fprc_pkg::ST_DIFF: begin
                diff_next  = $signed({2'b00, rem_reg[fprc_pkg::PERIOD_W-1:0]})
                           + ERR_W'(phase_reg);
                state_next = fprc_pkg::ST_WRAP;
            end
            fprc_pkg::ST_WRAP: begin
                // past half a period: the frame's pulse is still ahead
                if ($signed({diff_reg, 1'b0}) > $signed({3'b000, period_eff})) begin
                    diff_next = diff_reg - $signed({2'b00, period_eff});
                end
                state_next = fprc_pkg::ST_MUL;
            end
            fprc_pkg::ST_MUL: begin
                neg_next     = diff_reg[ERR_W-1];
                dvd_next     = DVD_W'(prod);
                rem_next     = '0;
                divisor_next = {period_eff, 2'b00};
                cnt_next     = '0;
                state_next   = fprc_pkg::ST_DIV_RATE;
            end
            fprc_pkg::ST_QUOT: begin
                // floor for negative numerators
                if (neg_reg) begin
                    q_next = -$signed({1'b0, dvd_reg[Q_W-2:0]})
                           - ((rem_reg != '0) ? Q_W'(1) : Q_W'(0));
                end else begin
                    q_next = $signed({1'b0, dvd_reg[Q_W-2:0]});
                end
                state_next = fprc_pkg::ST_RATE;
            end
            fprc_pkg::ST_RATE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load          = 1'b1;
                    m_err_next        = diff_reg;
                    m_rate_next       = rate_sat;
                    m_chg_next        = (rate_sat != current_rate_reg);
                    current_rate_next = rate_sat;
                    state_next        = fprc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fprc_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_phase_error_us = m_err_reg;
    assign m_new_rate       = m_rate_reg;
    assign m_rate_changed   = m_chg_reg;

    // the stored rate always tracks the last result loaded
    a_current_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (current_rate_reg == m_rate_reg))
        else $error("current rate does not match loaded result");

    // the step counter only runs inside a division
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != fprc_pkg::ST_DIV_REM && state_reg != fprc_pkg::ST_DIV_RATE)
        |-> (cnt_reg == '0))
        else $error("divider step counter running outside a division");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fprc_pkg::ST_DIV_REM || state_reg == fprc_pkg::ST_DIV_RATE)
        |-> (rem_reg < {1'b0, divisor_reg}))
        else $error("divider remainder out of range");

    // a stalled result holds still until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_phase_error_us)
                                   && $stable(m_new_rate) && $stable(m_rate_changed)))
        else $error("result dropped or changed while stalled");

    // an input transfer starts the sequence
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == fprc_pkg::ST_PULSE))
        else $error("transfer accepted without starting work");

endmodule

`default_nettype wire
